// ===== rtl/stsf_pkg.sv =====
// ----------------------------------------------------------------------------
// stsf_pkg
// Shared widths and the search token for the subarray target-sum finder.
// ----------------------------------------------------------------------------
package stsf_pkg;

   localparam int DEPTH          = 1024;
   localparam int VALUE_BITS     = 16;
   localparam int ELEMENT_BITS   = 16;
   localparam int SUM_BITS       = 26;
   localparam int INDEX_OUT_BITS = 10;
   localparam int IDX_BITS       = $clog2(DEPTH);
   localparam int CNT_BITS       = $clog2(DEPTH + 1);

   // one search beat travelling down the cell row
   typedef struct packed {
      logic                valid;
      logic                overflow;
      logic                found;
      logic [IDX_BITS-1:0] start;
      logic [IDX_BITS-1:0] idx;
      logic [SUM_BITS-1:0] want;
      logic [SUM_BITS-1:0] sum;
   } token_type;

endpackage

// ===== rtl/stsf_ifs.sv =====
// ----------------------------------------------------------------------------
// stsf request / response channels
// Valid/ready channels carrying array elements in and match results out.
// ----------------------------------------------------------------------------
interface stsf_req_if;
   logic                              valid;
   logic                              ready;
   logic                              first_item;
   logic [stsf_pkg::ELEMENT_BITS-1:0] element;

   modport source (output valid, first_item, element, input ready);
   modport sink   (input valid, first_item, element, output ready);
endinterface

interface stsf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic [stsf_pkg::INDEX_OUT_BITS-1:0] match_start;
   logic [stsf_pkg::INDEX_OUT_BITS-1:0] end_index;
   logic                                overflow;

   modport source (output valid, found, match_start, end_index, overflow, input ready);
   modport sink   (input valid, found, match_start, end_index, overflow, output ready);
endinterface

// ===== rtl/stsf_front.sv =====
// ----------------------------------------------------------------------------
// stsf_front
// Running prefix sum, element count and target register; builds the token
// that enters the cell row.
// ----------------------------------------------------------------------------
module stsf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic                              in_first,
   input  logic [stsf_pkg::ELEMENT_BITS-1:0] in_element,
   input  logic                              csr_wr_en,
   input  logic [stsf_pkg::SUM_BITS-1:0]     csr_wr_data,
   output stsf_pkg::token_type               tok_out
);

   logic [stsf_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [stsf_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [stsf_pkg::SUM_BITS-1:0] target_ff;

   logic [stsf_pkg::SUM_BITS-1:0] base_sum;
   logic [stsf_pkg::CNT_BITS-1:0] base_cnt;
   logic [stsf_pkg::SUM_BITS-1:0] elem_ext;
   logic [stsf_pkg::SUM_BITS-1:0] new_sum;
   logic [stsf_pkg::SUM_BITS-1:0] want;
   logic                          full;
   logic                          accept;

   always_comb begin
      accept   = in_valid && advance;
      base_sum = in_first ? '0 : sum_ff;
      base_cnt = in_first ? '0 : cnt_ff;
      full     = (base_cnt >= stsf_pkg::CNT_BITS'(stsf_pkg::DEPTH));
      elem_ext = stsf_pkg::SUM_BITS'(in_element[stsf_pkg::VALUE_BITS-1:0]);
      new_sum  = base_sum + elem_ext;
      want     = new_sum - target_ff;

      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept && !full) begin
         sum_in = new_sum;
         cnt_in = base_cnt + stsf_pkg::CNT_BITS'(1);
      end

      tok_out.valid    = accept;
      tok_out.overflow = full;
      // empty prefix match wins over every stored prefix
      tok_out.found    = !full && (want == '0);
      tok_out.start    = '0;
      tok_out.idx      = full ? '0 : base_cnt[stsf_pkg::IDX_BITS-1:0];
      tok_out.want     = want;
      tok_out.sum      = new_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         cnt_ff    <= '0;
         target_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== rtl/stsf_cell.sv =====
// ----------------------------------------------------------------------------
// stsf_cell
// One stored prefix sum and its comparator; passes the search token on.
// ----------------------------------------------------------------------------
module stsf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [stsf_pkg::IDX_BITS-1:0] cell_idx,
   input  stsf_pkg::token_type           tok_in,
   output stsf_pkg::token_type           tok_out
);

   stsf_pkg::token_type           tok_ff, tok_in_mod;
   logic [stsf_pkg::SUM_BITS-1:0] prefix_ff;
   logic                          live;
   logic                          hit;
   logic                          write;

   always_comb begin
      live  = tok_in.valid && !tok_in.overflow;
      // only prefixes written earlier in this array are compared
      hit   = live && !tok_in.found && (cell_idx < tok_in.idx) && (prefix_ff == tok_in.want);
      write = live && (cell_idx == tok_in.idx);

      tok_in_mod = tok_in;
      if (hit) begin
         tok_in_mod.found = 1'b1;
         tok_in_mod.start = cell_idx + stsf_pkg::IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_mod;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write) begin
         prefix_ff <= tok_in.sum;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/subarray_target_sum_finder_core.sv =====
// ----------------------------------------------------------------------------
// subarray_target_sum_finder_core
// Streams array elements and reports the earliest subarray ending at each
// element whose sum equals the programmed target.
//
// req_bus carries one element per beat; first_item marks the start of a new
// array and clears the running sum and count. rsp_bus returns exactly one
// result beat per element, in order. csr_wr_en/csr_wr_data load the 26-bit
// target; write it only while no beats are in flight.
//
// Each beat becomes a token that walks a row of DEPTH (1024) cells, one cell
// per cycle while the row is not stalled; cell k holds the prefix sum of
// element k and the token stores its own prefix as it passes the cell of its
// index. A result leaves the row from the register of the last cell, and one
// element is taken per cycle while the response is not stalled.
// The row is one shift chain: a stalled response holds every cell and drops
// req_bus.ready, so nothing is lost. Synchronous reset empties the row and
// clears the target, sum and count; req_bus.ready is low while reset is
// high. Stored prefixes need no clearing.
// ----------------------------------------------------------------------------
module subarray_target_sum_finder_core (
   input  logic                          clock,
   input  logic                          reset,
   stsf_req_if.sink                      req_bus,
   stsf_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [stsf_pkg::SUM_BITS-1:0] csr_wr_data
);

   stsf_pkg::token_type tok [stsf_pkg::DEPTH+1];
   logic                advance;

   assign advance     = !tok[stsf_pkg::DEPTH].valid || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;

   stsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_bus.valid),
      .in_first    (req_bus.first_item),
      .in_element  (req_bus.element),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .tok_out     (tok[0])
   );

   for (genvar k = 0; k < stsf_pkg::DEPTH; k++) begin : g_cell
      stsf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (stsf_pkg::IDX_BITS'(k)),
         .tok_in   (tok[k]),
         .tok_out  (tok[k+1])
      );
   end

   assign rsp_bus.valid       = tok[stsf_pkg::DEPTH].valid;
   assign rsp_bus.found       = tok[stsf_pkg::DEPTH].found;
   assign rsp_bus.match_start = stsf_pkg::INDEX_OUT_BITS'(tok[stsf_pkg::DEPTH].start);
   assign rsp_bus.end_index   = stsf_pkg::INDEX_OUT_BITS'(tok[stsf_pkg::DEPTH].idx);
   assign rsp_bus.overflow    = tok[stsf_pkg::DEPTH].overflow;

endmodule
